/* sv/msr_pkg.sv */
package msr_pkg;

	localparam int MAX_SIDE_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_W         = 16;
	localparam int SIDE_W        = 5;
	localparam int COUNT_W       = 8;
	localparam int RQ_W          = 18;
	localparam int BYTE_W        = 8;

	typedef enum logic [0:0] {
		REG_SAMPLES_SIDE = 1'b0,
		REG_MIN_WEIGHT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_x;
		logic signed [DATA_W-1:0] sample_y;
		logic signed [DATA_W-1:0] sample_z;
		logic signed [DATA_W-1:0] sample_w;
	} sample_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic q_load;
		logic q_step;
		logic acc;
		logic r_load;
		logic r_step;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_ACC,
		ST_RLOAD,
		ST_RDIV,
		ST_RDONE
	} state_t;

endpackage

/* sv/msaa_sample_resolve_top.sv */
// channel  | handshake                 | payload
// sample   | sample_valid/sample_ready | sample (x, y, z, w, signed Q16.16)
// pixel    | pixel_valid/pixel_ready   | pixel (red, green, blue bytes)
// cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// A sample passes through accept, setup, one quotient bit per cycle in three parallel
// restoring dividers, then accumulate.
// The sample that completes a pixel then adds load, 18 steps of the byte dividers
// (one quotient bit per cycle), and the output register load.
// A finished pixel waits in the output register while the next samples are taken;
// only the following pixel stalls on it. Reset: side 1, min weight 1, sums clear.
module msaa_sample_resolve_top
	import msr_pkg::*;
#(
	parameter int MAX_SIDE  = MAX_SIDE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  sample_t          sample,
	output logic             pixel_valid,
	input  logic             pixel_ready,
	output pixel_t           pixel,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int NW     = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int SDW    = $clog2(MAX_SIDE + 1);
	localparam int STEP_N = (FRAC_BITS > RQ_W) ? FRAC_BITS : RQ_W;
	localparam int CW     = $clog2(STEP_N);

	state_t              state_q;
	state_t              state_nxt;
	logic [CW-1:0]       step_q;
	logic [SIDE_W-1:0]   side_q;
	logic [CFG_W-1:0]    minw_q;
	logic [COUNT_W-1:0]  count_q;
	sample_t             smp_q;
	pixel_t              pixel_q;
	logic                pixel_valid_q;
	lane_ctrl_t          ctrl;
	logic [SDW-1:0]      side_eff;
	logic [NW-1:0]       n;
	logic                w_ok;
	logic                pixel_done;
	logic                out_load;
	logic                last_q_step;
	logic                last_r_step;
	logic [BYTE_W-1:0]   red_v;
	logic [BYTE_W-1:0]   green_v;
	logic [BYTE_W-1:0]   blue_v;

	always_comb begin
		if (side_q == '0)
			side_eff = SDW'(1);
		else if (side_q > SIDE_W'(MAX_SIDE))
			side_eff = SDW'(MAX_SIDE);
		else
			side_eff = SDW'(side_q);
		n = NW'(side_eff) * NW'(side_eff);
	end

	assign w_ok = !smp_q.sample_w[DATA_W-1] && (smp_q.sample_w[DATA_W-2:0] != '0)
		&& (smp_q.sample_w[DATA_W-2:0] >= (DATA_W - 1)'(minw_q));
	assign pixel_done  = ({1'b0, count_q} + 9'd1) >= 9'(n);
	assign last_q_step = step_q == CW'(FRAC_BITS - 1);
	assign last_r_step = step_q == CW'(RQ_W - 1);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (sample_valid) state_nxt = ST_SETUP;
			ST_SETUP: state_nxt = ST_DIV;
			ST_DIV:   if (last_q_step) state_nxt = ST_ACC;
			ST_ACC:   state_nxt = pixel_done ? ST_RLOAD : ST_IDLE;
			ST_RLOAD: state_nxt = ST_RDIV;
			ST_RDIV:  if (last_r_step) state_nxt = ST_RDONE;
			ST_RDONE: if (!pixel_valid_q || pixel_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl         = '0;
		sample_ready = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE:  sample_ready = 1'b1;
			ST_SETUP: ctrl.q_load = 1'b1;
			ST_DIV:   ctrl.q_step = 1'b1;
			ST_ACC:   ctrl.acc = 1'b1;
			ST_RLOAD: ctrl.r_load = 1'b1;
			ST_RDIV:  ctrl.r_step = 1'b1;
			ST_RDONE: out_load = !pixel_valid_q || pixel_ready;
			default:  ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.q_load || ctrl.r_load)
				step_q <= '0;
			else if (ctrl.q_step || ctrl.r_step)
				step_q <= step_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready)
			smp_q <= sample;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(1);
			minw_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLES_SIDE: side_q <= cfg_data[SIDE_W-1:0];
				REG_MIN_WEIGHT:   minw_q <= cfg_data;
				default:          side_q <= side_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.acc) begin
			count_q <= pixel_done ? '0 : count_q + COUNT_W'(1);
		end
	end

	msr_lane #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_red (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.num   (smp_q.sample_x),
		.den   (smp_q.sample_w[DATA_W-2:0]),
		.w_ok  (w_ok),
		.n     (n),
		.value (red_v)
	);

	msr_lane #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_green (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.num   (smp_q.sample_y),
		.den   (smp_q.sample_w[DATA_W-2:0]),
		.w_ok  (w_ok),
		.n     (n),
		.value (green_v)
	);

	msr_lane #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_blue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.num   (smp_q.sample_z),
		.den   (smp_q.sample_w[DATA_W-2:0]),
		.w_ok  (w_ok),
		.n     (n),
		.value (blue_v)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_q.red   <= red_v;
			pixel_q.green <= green_v;
			pixel_q.blue  <= blue_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid_q <= 1'b0;
		else if (out_load)
			pixel_valid_q <= 1'b1;
		else if (pixel_ready)
			pixel_valid_q <= 1'b0;
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> state_q == ST_SETUP)
		else $error("accepted sample did not start setup");

	a_count_adv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC && !pixel_done |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("sample count did not advance");

	a_pixel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC && pixel_done |=> state_q == ST_RLOAD && count_q == '0)
		else $error("pixel completion did not clear count");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> step_q <= CW'(FRAC_BITS - 1))
		else $error("quotient step count overran");

	a_pixel_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel_valid) |-> $past(state_q) == ST_RDONE)
		else $error("pixel raised outside resolve completion");

endmodule

/* sv/msr_sdiv.sv */
module msr_sdiv
	import msr_pkg::*;
#(
	parameter int DW = 31,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [DW-1:0] rem_init,
	input  logic [QW-1:0] dividend,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quot_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, num_q[QW-1]};
		ge    = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_init;
			num_q <= dividend;
		end else if (step) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q  <= {num_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign quot = quot_q;

endmodule

/* sv/msr_lane.sv */
module msr_lane
	import msr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW        = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] num,
	input  logic [DATA_W-2:0]        den,
	input  logic                     w_ok,
	input  logic [NW-1:0]            n,
	output logic [BYTE_W-1:0]        value
);

	localparam int SW = FRAC_BITS + 9;
	localparam int AW = FRAC_BITS + 1 + RQ_W;

	logic                 zero_q;
	logic                 full_q;
	logic [SW-1:0]        sum_q;
	logic [FRAC_BITS-1:0] quot;
	logic [FRAC_BITS:0]   addend;
	logic [AW-1:0]        scaled;
	logic [RQ_W-1:0]      rq;

	msr_sdiv #(
		.DW(DATA_W - 1),
		.QW(FRAC_BITS)
	) u_qdiv (
		.clk     (clk),
		.load    (ctrl.q_load),
		.step    (ctrl.q_step),
		.rem_init(num[DATA_W-2:0]),
		.dividend('0),
		.den     (den),
		.quot    (quot)
	);

	always_ff @(posedge clk) begin
		if (ctrl.q_load) begin
			zero_q <= !w_ok || num[DATA_W-1] || (num == '0);
			full_q <= num[DATA_W-2:0] >= den;
		end
	end

	always_comb begin
		if (zero_q)
			addend = '0;
		else if (full_q)
			addend = (FRAC_BITS + 1)'(1) << FRAC_BITS;
		else
			addend = {1'b0, quot};
		scaled = (AW'(sum_q) << 9) - (AW'(sum_q) << 1) + (AW'(n) << FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.r_load) begin
			sum_q <= '0;
		end else if (ctrl.acc) begin
			sum_q <= sum_q + SW'(addend);
		end
	end

	msr_sdiv #(
		.DW(NW),
		.QW(RQ_W)
	) u_rdiv (
		.clk     (clk),
		.load    (ctrl.r_load),
		.step    (ctrl.r_step),
		.rem_init('0),
		.dividend(scaled[AW-1:FRAC_BITS+1]),
		.den     (n),
		.quot    (rq)
	);

	assign value = (|rq[RQ_W-1:BYTE_W]) ? {BYTE_W{1'b1}} : rq[BYTE_W-1:0];

endmodule
